@@ src/prqea_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package prqea_pkg;

	// widest vertex address over the supported range of vertex counts
	localparam int ADDR_W = 24;

	localparam logic [1:0] CMD_LOAD   = 2'd0;
	localparam logic [1:0] CMD_EDGE   = 2'd1;
	localparam logic [1:0] CMD_UPDATE = 2'd2;

	localparam logic [1:0] RGN_LEFT  = 2'd0;
	localparam logic [1:0] RGN_RIGHT = 2'd1;
	localparam logic [1:0] RGN_TAIL  = 2'd2;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_RANGE    = 2'd1;
	localparam logic [1:0] STATUS_ZERO_DEG = 2'd2;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] vertex;
		logic [23:0] degree;
		logic [1:0]  region;
		logic [15:0] quad_x;
		logic [15:0] quad_y;
		logic [14:0] src_offset;
		logic [14:0] dest_offset;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] result_vertex;
		logic [31:0] score;
	} result_t;

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_EDGE,
		OP_UPDATE,
		OP_FLAG
	} op_kind_t;

	// classified command handed from front to back
	typedef struct packed {
		op_kind_t          kind;
		logic [1:0]        status;
		logic [15:0]       rv;
		logic [ADDR_W-1:0] addr_a;
		logic [ADDR_W-1:0] addr_b;
		logic [23:0]       degree;
	} op_t;

	typedef struct packed {
		logic [3:0]  side_len_log2;
		logic [16:0] wing_ofs;
		logic [16:0] vertex_count;
	} front_cfg_t;

	typedef struct packed {
		logic [31:0] damping;
		logic [31:0] teleport;
		logic [31:0] seed_rank;
	} back_cfg_t;

	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_READ,
		BK_EXEC,
		BK_SUM,
		BK_DIV
	} back_state_t;

endpackage
`default_nettype wire

@@ src/prqea_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
module prqea_fifo #(
	parameter type item_t = logic,
	parameter int  DEPTH  = 2
) (
	input  wire   clk,
	input  wire   arst_n,
	input  wire   push,
	input  item_t din,
	output logic  full,
	input  wire   pop,
	output item_t dout,
	output logic  empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t         mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop) rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	// store item
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= din;
	end

endmodule
`default_nettype wire

@@ src/prqea_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
module prqea_div (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	input  wire  [31:0] dividend,
	input  wire  [23:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);
	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [23:0] rem_q;
	logic [31:0] quo_q;
	logic [23:0] dvs_q;
	logic [24:0] trial;
	logic        ge;
	logic [24:0] diff;

	// one restoring step per cycle
	always_comb begin
		trial = {rem_q, quo_q[31]};
		ge    = (trial >= {1'b0, dvs_q});
		diff  = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[23:0] : trial[23:0];
			quo_q <= {quo_q[30:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

@@ src/prqea_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module prqea_front #(
	parameter int MAX_VERTICES = 65536
) (
	input  prqea_pkg::item_t      item,
	input  prqea_pkg::front_cfg_t cfg,
	output prqea_pkg::op_t        op
);
	import prqea_pkg::*;

	logic [32:0] qx_sc;
	logic [32:0] qy_sc;
	logic [32:0] u;
	logic [32:0] v;
	logic [32:0] vtx;
	logic        u_ok;
	logic        v_ok;
	logic        vtx_ok;

	function automatic logic addr_ok(input logic [32:0] a, input logic [16:0] cnt);
		return (a < {16'b0, cnt}) && (a < 33'(MAX_VERTICES));
	endfunction

	// form edge addresses at full width
	always_comb begin
		qx_sc = {17'b0, item.quad_x} << cfg.side_len_log2;
		qy_sc = {17'b0, item.quad_y} << cfg.side_len_log2;
		if (item.region == RGN_TAIL) begin
			u = {17'b0, item.quad_x} + {18'b0, item.src_offset};
			v = {17'b0, item.quad_y} + {18'b0, item.dest_offset};
		end else begin
			u = qx_sc + {18'b0, item.src_offset};
			v = qy_sc + {18'b0, item.dest_offset};
			if (item.region == RGN_RIGHT) v = v + {16'b0, cfg.wing_ofs};
		end
		vtx    = {17'b0, item.vertex};
		u_ok   = addr_ok(u, cfg.vertex_count);
		v_ok   = addr_ok(v, cfg.vertex_count);
		vtx_ok = addr_ok(vtx, cfg.vertex_count);
	end

	// classify command
	always_comb begin
		op.kind   = OP_FLAG;
		op.status = STATUS_RANGE;
		op.rv     = '0;
		op.addr_a = vtx[ADDR_W-1:0];
		op.addr_b = vtx[ADDR_W-1:0];
		op.degree = item.degree;
		unique case (item.cmd)
			CMD_LOAD: begin
				op.rv = item.vertex;
				if (!vtx_ok) op.kind = OP_FLAG;
				else if (item.degree == '0) op.status = STATUS_ZERO_DEG;
				else begin
					op.kind   = OP_LOAD;
					op.status = STATUS_OK;
				end
			end
			CMD_EDGE: begin
				op.rv     = v[15:0];
				op.addr_a = u[ADDR_W-1:0];
				op.addr_b = v[ADDR_W-1:0];
				if (item.region != 2'd3 && u_ok && v_ok) begin
					op.kind   = OP_EDGE;
					op.status = STATUS_OK;
				end
			end
			CMD_UPDATE: begin
				op.rv = item.vertex;
				if (vtx_ok) begin
					op.kind   = OP_UPDATE;
					op.status = STATUS_OK;
				end
			end
			default: begin
				op.rv = '0;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ src/prqea_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module prqea_back #(
	parameter int MAX_VERTICES = 65536
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  prqea_pkg::back_cfg_t cfg,
	input  wire                  cmd_empty,
	input  prqea_pkg::op_t       cmd_op,
	output logic                 cmd_pop,
	input  wire                  res_full,
	output logic                 res_push,
	output prqea_pkg::result_t   res_data,
	output logic                 clearing
);
	import prqea_pkg::*;

	localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

	logic [31:0] cont_mem [MAX_VERTICES];
	logic [31:0] acc_mem  [MAX_VERTICES];
	logic [23:0] deg_mem  [MAX_VERTICES];

	back_state_t state_q, state_d;
	op_t         op_q;
	logic [AW-1:0] clr_q;
	logic [31:0] cont_rd_s1;
	logic [31:0] acc_rd_s1;
	logic [23:0] deg_rd_s1;
	logic [63:0] prod_q;
	logic [31:0] score_q;
	logic [31:0] score_d;
	logic [AW-1:0] ia;
	logic [AW-1:0] ib;

	logic        acc_we;
	logic [AW-1:0] acc_wa;
	logic [31:0] acc_wd;
	logic        cont_we;
	logic        deg_we;
	logic        mul_en;
	logic        div_start;
	logic [31:0] div_dividend;
	logic [23:0] div_divisor;
	logic        div_done;
	logic [31:0] div_quo;

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	assign ia       = op_q.addr_a[AW-1:0];
	assign ib       = op_q.addr_b[AW-1:0];
	assign clearing = (state_q == BK_CLEAR);
	assign score_d  = sat_add(cfg.teleport, prod_q[63:32]);

	prqea_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_CLEAR) clr_q <= clr_q + 1'b1;
		end
	end

	// next state and controls
	always_comb begin
		state_d      = state_q;
		cmd_pop      = 1'b0;
		res_push     = 1'b0;
		res_data     = '{status: op_q.status, result_vertex: op_q.rv, score: 32'd0};
		acc_we       = 1'b0;
		acc_wa       = ib;
		acc_wd       = '0;
		cont_we      = 1'b0;
		deg_we       = 1'b0;
		mul_en       = 1'b0;
		div_start    = 1'b0;
		div_dividend = cfg.seed_rank;
		div_divisor  = op_q.degree;
		unique case (state_q)
			BK_CLEAR: begin
				acc_we = 1'b1;
				acc_wa = clr_q;
				if (clr_q == AW'(MAX_VERTICES - 1)) state_d = BK_IDLE;
			end
			BK_IDLE: begin
				if (!cmd_empty && !res_full) begin
					cmd_pop = 1'b1;
					state_d = BK_READ;
				end
			end
			BK_READ: state_d = BK_EXEC;
			BK_EXEC: begin
				unique case (op_q.kind)
					OP_LOAD: begin
						div_start = 1'b1;
						state_d   = BK_DIV;
					end
					OP_EDGE: begin
						acc_we   = 1'b1;
						acc_wd   = sat_add(acc_rd_s1, cont_rd_s1);
						res_push = 1'b1;
						state_d  = BK_IDLE;
					end
					OP_UPDATE: begin
						if (deg_rd_s1 == '0) begin
							res_data.status = STATUS_ZERO_DEG;
							res_push        = 1'b1;
							state_d         = BK_IDLE;
						end else begin
							mul_en  = 1'b1;
							state_d = BK_SUM;
						end
					end
					default: begin
						res_push = 1'b1;
						state_d  = BK_IDLE;
					end
				endcase
			end
			BK_SUM: begin
				div_start    = 1'b1;
				div_dividend = score_d;
				div_divisor  = deg_rd_s1;
				state_d      = BK_DIV;
			end
			BK_DIV: begin
				if (div_done) begin
					cont_we  = 1'b1;
					deg_we   = (op_q.kind == OP_LOAD);
					acc_we   = (op_q.kind == OP_UPDATE);
					res_push = 1'b1;
					if (op_q.kind == OP_UPDATE) res_data.score = score_q;
					state_d  = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// latch command and arithmetic results
	always_ff @(posedge clk) begin
		if (cmd_pop) op_q <= cmd_op;
		if (mul_en) prod_q <= {32'b0, cfg.damping} * {32'b0, acc_rd_s1};
		if (state_q == BK_SUM) score_q <= score_d;
	end

	// registered reads
	always_ff @(posedge clk) begin
		cont_rd_s1 <= cont_mem[ia];
		acc_rd_s1  <= acc_mem[ib];
		deg_rd_s1  <= deg_mem[ia];
	end

	// write memories
	always_ff @(posedge clk) begin
		if (acc_we) acc_mem[acc_wa] <= acc_wd;
	end

	always_ff @(posedge clk) begin
		if (cont_we) cont_mem[ia] <= div_quo;
	end

	always_ff @(posedge clk) begin
		if (deg_we) deg_mem[ia] <= op_q.degree;
	end

	a_res_space: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into full queue");

	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_CLEAR) |-> !cmd_pop)
		else $error("command taken during clearing pass");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (div_divisor != '0))
		else $error("divide by zero degree");

	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> (state_q == BK_DIV))
		else $error("divider started outside divide wait");

endmodule
`default_nettype wire

@@ src/pagerank_quad_edge_accumulate.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Flow: an accepted item is queued, popped by the back end, read from memory, then
// executed. Edge, flagged and zero-degree update items return a result from the execute
// step; loads and other updates first run through the 32-step radix-2 divider, updates
// after a multiply and a sum step. The back end takes one item at a time; a 2-entry
// command queue and a 2-entry result queue decouple the ports.
// Reset: asynchronous, active low; then a clearing pass zeroes the accumulator memory
// while full stays high (configuration writes still taken).
module pagerank_quad_edge_accumulate #(
	parameter int MAX_VERTICES = 65536
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	output logic               full,
	input  prqea_pkg::item_t   item,
	output logic               empty,
	input  wire                pop,
	output prqea_pkg::result_t result,
	input  wire                psel,
	input  wire                penable,
	input  wire                pwrite,
	input  wire  [4:0]         paddr,
	input  wire  [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import prqea_pkg::*;

	localparam logic [2:0] REG_SIDE_LOG2  = 3'd0;
	localparam logic [2:0] REG_WING       = 3'd1;
	localparam logic [2:0] REG_VCOUNT     = 3'd2;
	localparam logic [2:0] REG_DAMPING    = 3'd3;
	localparam logic [2:0] REG_BASE       = 3'd4;
	localparam logic [2:0] REG_INIT       = 3'd5;

	logic [3:0]  side_len_log2_q;
	logic [16:0] wing_ofs_q;
	logic [16:0] vertex_count_q;
	logic [31:0] damping_q;
	logic [31:0] teleport_q;
	logic [31:0] seed_rank_q;

	front_cfg_t fcfg;
	back_cfg_t  bcfg;
	op_t        front_op;
	op_t        cmd_op;
	logic       cmd_full;
	logic       cmd_empty;
	logic       cmd_pop;
	logic       res_full;
	logic       res_push;
	result_t    res_data;
	logic       clearing;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_len_log2_q <= 4'd4;
			wing_ofs_q      <= '0;
			vertex_count_q  <= 17'd65536;
			damping_q       <= 32'd3650722202;
			teleport_q      <= '0;
			seed_rank_q     <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_SIDE_LOG2: side_len_log2_q <= pwdata[3:0];
				REG_WING:      wing_ofs_q      <= pwdata[16:0];
				REG_VCOUNT:    vertex_count_q  <= pwdata[16:0];
				REG_DAMPING:   damping_q       <= pwdata;
				REG_BASE:      teleport_q      <= pwdata;
				REG_INIT:      seed_rank_q     <= pwdata;
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (paddr[4:2])
			REG_SIDE_LOG2: prdata = {28'b0, side_len_log2_q};
			REG_WING:      prdata = {15'b0, wing_ofs_q};
			REG_VCOUNT:    prdata = {15'b0, vertex_count_q};
			REG_DAMPING:   prdata = damping_q;
			REG_BASE:      prdata = teleport_q;
			REG_INIT:      prdata = seed_rank_q;
			default:       prdata = '0;
		endcase
	end

	assign fcfg = '{side_len_log2: side_len_log2_q, wing_ofs: wing_ofs_q,
		vertex_count: vertex_count_q};
	assign bcfg = '{damping: damping_q, teleport: teleport_q,
		seed_rank: seed_rank_q};

	// hold off input during the clearing pass
	assign full = cmd_full || clearing;

	prqea_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
		.item (item),
		.cfg  (fcfg),
		.op   (front_op)
	);

	prqea_fifo #(.item_t(op_t), .DEPTH(2)) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push && !full),
		.din    (front_op),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.dout   (cmd_op),
		.empty  (cmd_empty)
	);

	prqea_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (bcfg),
		.cmd_empty (cmd_empty),
		.cmd_op    (cmd_op),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_data  (res_data),
		.clearing  (clearing)
	);

	prqea_fifo #(.item_t(result_t), .DEPTH(2)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res_data),
		.full   (res_full),
		.pop    (pop),
		.dout   (result),
		.empty  (empty)
	);

endmodule
`default_nettype wire
